// ===== rtl/core/exs_pkg.sv =====
// exchange sorter package: control word, branch conditions and microcode rom
package exs_pkg;

  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned DataW       = 16;
  localparam int unsigned StepW       = 3;

  localparam logic [StepW-1:0] StepLoad = 3'd0;
  localparam logic [StepW-1:0] StepRdX  = 3'd1;
  localparam logic [StepW-1:0] StepLdX  = 3'd2;
  localparam logic [StepW-1:0] StepCmp  = 3'd3;
  localparam logic [StepW-1:0] StepWrX  = 3'd4;
  localparam logic [StepW-1:0] StepRdK  = 3'd5;
  localparam logic [StepW-1:0] StepLdO  = 3'd6;
  localparam logic [StepW-1:0] StepSnd  = 3'd7;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_CLOSE,
    COND_Y_END,
    COND_Y_LAST,
    COND_X_LAST,
    COND_OUT_FREE,
    COND_K_END
  } cond_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_X,
    RD_Y,
    RD_YN,
    RD_K
  } rsel_e;

  typedef struct packed {
    logic             accept;
    logic             idx_clr;
    logic             x_inc;
    logic             y_set;
    logic             y_inc;
    logic             cur_ld;
    logic             swap;
    logic             wr_x;
    logic             k_inc;
    logic             out_ld;
    logic             set_clr;
    rsel_e            rsel;
    cond_e            cond;
    logic [StepW-1:0] tgt_t;
    logic [StepW-1:0] tgt_f;
  } ctl_t;

  typedef struct packed {
    logic close;
    logic y_end;
    logic y_last;
    logic x_last;
    logic out_free;
    logic k_end;
  } stat_t;

  function automatic ctl_t useq_rom(input logic [StepW-1:0] pc);
    ctl_t w;
    w = '0;
    w.rsel = RD_NONE;
    w.cond = COND_ALWAYS;
    unique case (pc)
      StepLoad: begin
        w.accept  = 1'b1;
        w.idx_clr = 1'b1;
        w.cond    = COND_CLOSE;
        w.tgt_t   = StepRdX;
        w.tgt_f   = StepLoad;
      end
      StepRdX: begin
        w.rsel  = RD_X;
        w.y_set = 1'b1;
        w.tgt_t = StepLdX;
        w.tgt_f = StepLdX;
      end
      StepLdX: begin
        w.cur_ld = 1'b1;
        w.rsel   = RD_Y;
        w.cond   = COND_Y_END;
        w.tgt_t  = StepWrX;
        w.tgt_f  = StepCmp;
      end
      StepCmp: begin
        w.swap  = 1'b1;
        w.rsel  = RD_YN;
        w.y_inc = 1'b1;
        w.cond  = COND_Y_LAST;
        w.tgt_t = StepWrX;
        w.tgt_f = StepCmp;
      end
      StepWrX: begin
        w.wr_x  = 1'b1;
        w.x_inc = 1'b1;
        w.cond  = COND_X_LAST;
        w.tgt_t = StepRdK;
        w.tgt_f = StepRdX;
      end
      StepRdK: begin
        w.rsel  = RD_K;
        w.tgt_t = StepLdO;
        w.tgt_f = StepLdO;
      end
      StepLdO: begin
        w.out_ld = 1'b1;
        w.k_inc  = 1'b1;
        w.cond   = COND_OUT_FREE;
        w.tgt_t  = StepSnd;
        w.tgt_f  = StepLdO;
      end
      StepSnd: begin
        w.rsel    = RD_K;
        w.set_clr = 1'b1;
        w.cond    = COND_K_END;
        w.tgt_t   = StepLoad;
        w.tgt_f   = StepLdO;
      end
      default: begin
        w.tgt_t = StepLoad;
        w.tgt_f = StepLoad;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/exchange_sorter.sv =====
// exchange sorter top level: element memory, index counters and result register
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o   | value_i, last_item_i
//  out     | output    | out_valid_o / out_stall_i | sorted_value_o, last_result_o, dropped_o
//
// while loading, every transfer is taken; a closing transfer starts the sort
// the sort does one compare per cycle in its compare step,
// set by the single read and write port of the element memory
// results leave at most one per pass through the LdO and Snd steps; out_stall_i holds the sequencer
// while a set is sorted or emitted, in_stall_o is high
// reset clears the counters, the overflow flag, the result valid and the sequencer, not the memory
module exchange_sorter #(
  parameter int unsigned MAX_ITEMS = exs_pkg::MaxItemsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [exs_pkg::DataW-1:0] value_i,
  input  logic                      last_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [exs_pkg::DataW-1:0] sorted_value_o,
  output logic                      last_result_o,
  output logic                      dropped_o
);

  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AddrW = $clog2(MAX_ITEMS);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ITEMS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  exs_pkg::ctl_t  ctl;
  exs_pkg::stat_t stat;
  logic           take;

  logic [exs_pkg::DataW-1:0] mem [MAX_ITEMS];
  logic [exs_pkg::DataW-1:0] rdata_q, cur_q;
  logic [CntW-1:0]           count_q, x_q, y_q, k_q;
  logic [CntW-1:0]           x_nxt, y_nxt, k_nxt;
  logic                      ovf_q;
  logic                      out_valid_q, out_last_q, out_drop_q;
  logic [exs_pkg::DataW-1:0] out_value_q;

  logic                      in_xfer, room, load_we, swap_hit, out_ld;
  logic                      mem_we, mem_re;
  logic [AddrW-1:0]          waddr, raddr;
  logic [exs_pkg::DataW-1:0] wdata;

  exs_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl),
    .take_o (take)
  );

  assign in_stall_o = !ctl.accept;
  assign in_xfer    = in_valid_i && ctl.accept;
  assign room       = count_q != MaxCnt;
  assign load_we    = in_xfer && room;
  assign swap_hit   = ctl.swap && (cur_q > rdata_q);
  assign out_ld     = ctl.out_ld && take;

  assign x_nxt = x_q + CntOne;
  assign y_nxt = y_q + CntOne;
  assign k_nxt = k_q + CntOne;

  assign stat.close    = in_valid_i && last_item_i;
  assign stat.y_end    = y_q >= count_q;
  assign stat.y_last   = y_nxt >= count_q;
  assign stat.x_last   = x_nxt >= count_q;
  assign stat.out_free = !out_valid_q || !out_stall_i;
  assign stat.k_end    = k_q >= count_q;

  always_comb begin
    mem_we = load_we || swap_hit || ctl.wr_x;
    waddr  = count_q[AddrW-1:0];
    wdata  = value_i;
    if (swap_hit) begin
      waddr = y_q[AddrW-1:0];
      wdata = cur_q;
    end else if (ctl.wr_x) begin
      waddr = x_q[AddrW-1:0];
      wdata = cur_q;
    end
    mem_re = ctl.rsel != exs_pkg::RD_NONE;
    case (ctl.rsel)
      exs_pkg::RD_X:  raddr = x_q[AddrW-1:0];
      exs_pkg::RD_Y:  raddr = y_q[AddrW-1:0];
      exs_pkg::RD_YN: raddr = y_nxt[AddrW-1:0];
      exs_pkg::RD_K:  raddr = k_q[AddrW-1:0];
      default:        raddr = '0;
    endcase
  end

  // element memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // running minimum for position x
  always_ff @(posedge clk_i) begin
    if (ctl.cur_ld || swap_hit) begin
      cur_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      k_q     <= '0;
    end else begin
      if (in_xfer) begin
        if (room) begin
          count_q <= count_q + CntOne;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (ctl.set_clr && take) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
      if (ctl.idx_clr) begin
        x_q <= '0;
        k_q <= '0;
      end
      if (ctl.x_inc) begin
        x_q <= x_nxt;
      end
      if (ctl.y_set) begin
        y_q <= x_nxt;
      end
      if (ctl.y_inc) begin
        y_q <= y_nxt;
      end
      if (ctl.k_inc && take) begin
        k_q <= k_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_value_q <= rdata_q;
      out_last_q  <= k_nxt == count_q;
      out_drop_q  <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_result_o  = out_last_q;
  assign dropped_o      = out_drop_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("element count beyond capacity");

  a_close_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_item_i) |=> in_stall_o)
    else $error("input taken after a closing transfer");

  a_swap_lowers_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    swap_hit |=> cur_q < $past(cur_q))
    else $error("swap did not lower the running minimum");

  a_results_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ld && k_q != '0) |-> rdata_q >= out_value_q)
    else $error("results not in ascending order");

endmodule

// ===== rtl/core/exs_useq.sv =====
// exchange sorter microsequencer: step counter, rom lookup and branch select
module exs_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  exs_pkg::stat_t  stat_i,
  output exs_pkg::ctl_t   ctl_o,
  output logic            take_o
);

  logic [exs_pkg::StepW-1:0] pc_q, pc_d;

  always_comb begin
    ctl_o = exs_pkg::useq_rom(pc_q);
    case (ctl_o.cond)
      exs_pkg::COND_ALWAYS:   take_o = 1'b1;
      exs_pkg::COND_CLOSE:    take_o = stat_i.close;
      exs_pkg::COND_Y_END:    take_o = stat_i.y_end;
      exs_pkg::COND_Y_LAST:   take_o = stat_i.y_last;
      exs_pkg::COND_X_LAST:   take_o = stat_i.x_last;
      exs_pkg::COND_OUT_FREE: take_o = stat_i.out_free;
      exs_pkg::COND_K_END:    take_o = stat_i.k_end;
      default:                take_o = 1'b1;
    endcase
    pc_d = take_o ? ctl_o.tgt_t : ctl_o.tgt_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= exs_pkg::StepLoad;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
